>>> src/bdf_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and line-lexer helper functions for the BDF glyph parser.
// Has no dependencies. It is used by bdf_glyph_stream_parser.

package bdf_pkg;

   typedef enum logic [6:0] {
      PH_LEAD   = 7'b0000001,
      PH_TOKEN  = 7'b0000010,
      PH_RUN    = 7'b0000100,
      PH_ARG    = 7'b0001000,
      PH_SIGN   = 7'b0010000,
      PH_DIGITS = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_NIBBLE = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   localparam logic [2:0] KW_ENCODING = 3'd0;
   localparam logic [2:0] KW_DWIDTH   = 3'd1;
   localparam logic [2:0] KW_BBX      = 3'd2;
   localparam logic [2:0] KW_BITMAP   = 3'd3;
   localparam logic [2:0] KW_ENDCHAR  = 3'd4;
   localparam int unsigned NUM_KW     = 5;

   // Keyword text is left-aligned: the first letter sits in the top byte.
   localparam logic [NUM_KW-1:0][63:0] KW_TEXT = {
      {"ENDCHAR", 8'd0},
      {"BITMAP", 16'd0},
      {"BBX", 40'd0},
      {"DWIDTH", 16'd0},
      "ENCODING"
   };
   localparam logic [NUM_KW-1:0][3:0] KW_LEN = {4'd7, 4'd6, 4'd3, 4'd6, 4'd8};

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [8:0] TLEN_MAX = 9'd511;
   localparam logic [15:0] ROW_MAX = 16'hFFFF;

   typedef struct packed {
      phase_type         ph;
      logic [4:0]        cand;
      logic [8:0]        tlen;
      logic              quoted;
      logic [2:0]        aidx;
      logic [31:0]       acc;
      logic              neg;
      logic [31:0]       enc;
      logic [1:0][31:0]  adv;
      logic [3:0][31:0]  box;
   } lex_type;

   typedef struct packed {
      kind_type     kind;
      logic [31:0]  code_point;
      logic [31:0]  advance_x;
      logic [31:0]  advance_y;
      logic [31:0]  box_width;
      logic [31:0]  box_height;
      logic [31:0]  box_x_offset;
      logic [31:0]  box_y_offset;
      logic [9:0]   pixel_column;
      logic [15:0]  pixel_row;
      logic [3:0]   nibble;
   } rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         v = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         v = 4'(c[2:0] + 3'd1) + 4'd8;
      end
      return v;
   endfunction

   function automatic logic [4:0] kw_hits(input lex_type s);
      logic [4:0] h;
      for (int k = 0; k < NUM_KW; k++) begin
         h[k] = s.cand[k] && (s.tlen == {5'd0, KW_LEN[k]});
      end
      return h;
   endfunction

   function automatic logic [2:0] arg_count(input lex_type s);
      logic [4:0] h;
      logic [2:0] n;
      h = kw_hits(s);
      n = 3'd0;
      if (h[KW_ENCODING]) begin
         n = 3'd1;
      end else if (h[KW_DWIDTH]) begin
         n = 3'd2;
      end else if (h[KW_BBX]) begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic lex_type token_char(input lex_type s, input logic [7:0] c);
      lex_type r;
      r = s;
      for (int k = 0; k < NUM_KW; k++) begin
         if ((s.tlen >= {5'd0, KW_LEN[k]}) ||
             (KW_TEXT[k][{~s.tlen[2:0], 3'b000} +: 8] != c)) begin
            r.cand[k] = 1'b0;
         end
      end
      if (s.tlen != TLEN_MAX) begin
         r.tlen = s.tlen + 9'd1;
      end
      return r;
   endfunction

   function automatic lex_type store_at(input lex_type s, input logic [2:0] idx,
                                        input logic [31:0] v);
      lex_type r;
      logic [4:0] h;
      r = s;
      h = kw_hits(s);
      if (h[KW_ENCODING]) begin
         if (idx == 3'd0) begin
            r.enc = v;
         end
      end else if (h[KW_DWIDTH]) begin
         if (idx < 3'd2) begin
            r.adv[idx[0]] = v;
         end
      end else if (h[KW_BBX]) begin
         if (idx < 3'd4) begin
            r.box[idx[1:0]] = v;
         end
      end
      return r;
   endfunction

   function automatic lex_type token_end(input lex_type s, input logic bmode);
      lex_type r;
      logic [4:0] h;
      r = s;
      h = kw_hits(s);
      if (bmode || arg_count(s) == 3'd0) begin
         r.ph = PH_DONE;
      end else begin
         // Arguments that never show up read as zero.
         if (h[KW_ENCODING]) begin
            r.enc = '0;
         end else if (h[KW_DWIDTH]) begin
            r.adv = '0;
         end else begin
            r.box = '0;
         end
         r.aidx = 3'd0;
         r.acc  = '0;
         r.neg  = 1'b0;
         r.ph   = PH_ARG;
      end
      return r;
   endfunction

   function automatic lex_type commit_arg(input lex_type s);
      lex_type r;
      r = store_at(s, s.aidx, s.neg ? (32'd0 - s.acc) : s.acc);
      r.aidx = s.aidx + 3'd1;
      r.acc  = '0;
      r.neg  = 1'b0;
      r.ph   = (r.aidx >= arg_count(s)) ? PH_DONE : PH_ARG;
      return r;
   endfunction

   function automatic lex_type arg_start(input lex_type s, input logic [7:0] c);
      lex_type r;
      r = s;
      if (c > CH_SPACE) begin
         if (c == CH_MINUS) begin
            r.neg = 1'b1;
            r.acc = '0;
            r.ph  = PH_SIGN;
         end else if (is_digit(c)) begin
            r.acc = {28'd0, c[3:0]};
            r.ph  = PH_DIGITS;
         end else begin
            r.ph = PH_DONE;
         end
      end
      return r;
   endfunction

   function automatic lex_type finalize(input lex_type s, input logic bmode);
      lex_type r;
      r = s;
      if (s.ph == PH_TOKEN || s.ph == PH_RUN) begin
         r = token_end(s, bmode);
      end else if (s.ph == PH_SIGN || s.ph == PH_DIGITS) begin
         r = commit_arg(s);
      end
      r.ph = PH_DONE;
      return r;
   endfunction

endpackage

>>> src/bdf_glyph_stream_parser.sv
`timescale 1ns / 1ps
// BDF glyph stream parser: a byte-wide line lexer with a two-entry result buffer.
// Depends on bdf_pkg for types, character codes and the lexer functions.
//
//   channel | direction | ports                              | accepted when
//   --------+-----------+------------------------------------+-------------------------
//   req     | in        | req_valid, req_stall, req_ch       | req_valid && !req_stall
//   rsp     | out       | rsp_valid, rsp_stall, rsp_kind ... | rsp_valid && !rsp_stall
//
// One byte is taken per clock cycle while req_stall is low; the whole lexer step for
// that byte is done between the state registers and the result register or, while
// that is held, the skid entry. A result register plus one skid entry sit on the
// output; req_stall rises only while the skid entry is occupied. Reset is synchronous
// and active high and leaves the lexer at the start of a line outside a bitmap.

module bdf_glyph_stream_parser #(
   parameter int MAX_LINE = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_ch,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic signed [31:0]  rsp_code_point,
   output logic signed [31:0]  rsp_advance_x,
   output logic signed [31:0]  rsp_advance_y,
   output logic signed [31:0]  rsp_box_width,
   output logic signed [31:0]  rsp_box_height,
   output logic signed [31:0]  rsp_box_x_offset,
   output logic signed [31:0]  rsp_box_y_offset,
   output logic [9:0]          rsp_pixel_column,
   output logic [15:0]         rsp_pixel_row,
   output logic [3:0]          rsp_nibble
);

   localparam int LPOS_W = $clog2(MAX_LINE);
   localparam logic [LPOS_W-1:0] LPOS_LAST = LPOS_W'(MAX_LINE - 1);

   bdf_pkg::lex_type   lex_ff, lex_in, s_v;
   logic               bmode_ff, bmode_in;
   logic [LPOS_W-1:0]  lpos_ff, lpos_in;
   logic [9:0]         col_ff, col_in;
   logic [15:0]        row_ff, row_in;

   bdf_pkg::rsp_type   out_ff, out_in, skid_ff, skid_in, res_new;
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic               res_valid;
   logic               accept, take, line_end;
   logic [4:0]         hits;

   assign accept = req_valid && !skid_valid_ff;
   assign take   = out_valid_ff && !rsp_stall;

   // Lexer step for one byte.
   always_comb begin
      s_v       = lex_ff;
      bmode_in  = bmode_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      res_new   = '0;
      res_valid = 1'b0;
      lpos_in   = lpos_ff + LPOS_W'(1);
      line_end  = 1'b0;
      hits      = '0;

      if (s_v.ph != bdf_pkg::PH_DONE) begin
         if (req_ch == bdf_pkg::CH_NUL) begin
            s_v = bdf_pkg::finalize(s_v, bmode_ff);
         end else begin
            case (s_v.ph)
               bdf_pkg::PH_LEAD: begin
                  if (req_ch > bdf_pkg::CH_SPACE) begin
                     if (req_ch == bdf_pkg::CH_QUOTE) begin
                        s_v.quoted = 1'b1;
                        s_v.ph     = bdf_pkg::PH_TOKEN;
                     end else begin
                        s_v = bdf_pkg::token_char(s_v, req_ch);
                        if (bmode_ff && req_ch >= bdf_pkg::CH_ZERO) begin
                           res_valid = 1'b1;
                           s_v.ph    = bdf_pkg::PH_RUN;
                        end else begin
                           s_v.ph = bdf_pkg::PH_TOKEN;
                        end
                     end
                  end
               end
               bdf_pkg::PH_TOKEN: begin
                  if (s_v.quoted) begin
                     if (req_ch == bdf_pkg::CH_QUOTE) begin
                        s_v = bdf_pkg::token_end(s_v, bmode_ff);
                     end else begin
                        s_v = bdf_pkg::token_char(s_v, req_ch);
                     end
                  end else if (req_ch <= bdf_pkg::CH_SPACE) begin
                     s_v = bdf_pkg::token_end(s_v, bmode_ff);
                  end else begin
                     s_v = bdf_pkg::token_char(s_v, req_ch);
                  end
               end
               bdf_pkg::PH_RUN: begin
                  if (req_ch <= bdf_pkg::CH_SPACE) begin
                     s_v = bdf_pkg::token_end(s_v, bmode_ff);
                  end else begin
                     s_v = bdf_pkg::token_char(s_v, req_ch);
                     if (req_ch >= bdf_pkg::CH_ZERO) begin
                        res_valid = 1'b1;
                     end else begin
                        s_v.ph = bdf_pkg::PH_TOKEN;
                     end
                  end
               end
               bdf_pkg::PH_ARG: begin
                  s_v = bdf_pkg::arg_start(s_v, req_ch);
               end
               bdf_pkg::PH_SIGN, bdf_pkg::PH_DIGITS: begin
                  if (bdf_pkg::is_digit(req_ch)) begin
                     if (s_v.ph == bdf_pkg::PH_SIGN) begin
                        s_v.acc = {28'd0, req_ch[3:0]};
                     end else begin
                        s_v.acc = (s_v.acc << 3) + (s_v.acc << 1) + {28'd0, req_ch[3:0]};
                     end
                     s_v.ph = bdf_pkg::PH_DIGITS;
                  end else if (!(s_v.ph == bdf_pkg::PH_SIGN && req_ch <= bdf_pkg::CH_SPACE)) begin
                     // A '-' right after a number opens the next argument at once.
                     s_v = bdf_pkg::commit_arg(s_v);
                     if (s_v.ph == bdf_pkg::PH_ARG) begin
                        s_v = bdf_pkg::arg_start(s_v, req_ch);
                     end
                  end
               end
               default: begin
                  s_v.ph = bdf_pkg::PH_DONE;
               end
            endcase
         end
      end

      if (res_valid) begin
         res_new.kind         = bdf_pkg::KIND_NIBBLE;
         res_new.pixel_column = col_ff;
         res_new.pixel_row    = row_ff;
         res_new.nibble       = bdf_pkg::hex_value(req_ch);
         col_in               = col_ff + 10'd4;
      end

      if (req_ch == bdf_pkg::CH_NEWLINE || lpos_in >= LPOS_LAST) begin
         line_end = 1'b1;
         s_v  = bdf_pkg::finalize(s_v, bmode_ff);
         hits = bdf_pkg::kw_hits(s_v);
         if (bmode_ff) begin
            if (hits[bdf_pkg::KW_ENDCHAR]) begin
               bmode_in = 1'b0;
            end else if (s_v.tlen != 9'd0 && row_ff != bdf_pkg::ROW_MAX) begin
               row_in = row_ff + 16'd1;
            end
         end else begin
            row_in = '0;
            if (hits[bdf_pkg::KW_BITMAP]) begin
               res_new              = '0;
               res_new.kind         = bdf_pkg::KIND_HEADER;
               res_new.code_point   = s_v.enc;
               res_new.advance_x    = s_v.adv[0];
               res_new.advance_y    = s_v.adv[1];
               res_new.box_width    = s_v.box[0];
               res_new.box_height   = s_v.box[1];
               res_new.box_x_offset = s_v.box[2];
               res_new.box_y_offset = s_v.box[3];
               res_valid            = 1'b1;
               bmode_in             = 1'b1;
            end else if (hits[bdf_pkg::KW_ENDCHAR]) begin
               res_new      = '0;
               res_new.kind = bdf_pkg::KIND_ERROR;
               res_valid    = 1'b1;
            end
         end
         s_v.ph     = bdf_pkg::PH_LEAD;
         s_v.cand   = '1;
         s_v.tlen   = '0;
         s_v.quoted = 1'b0;
         s_v.aidx   = '0;
         s_v.acc    = '0;
         s_v.neg    = 1'b0;
         col_in     = '0;
         lpos_in    = '0;
      end
      lex_in = s_v;
   end

   // Result register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff && !take;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (accept && res_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = res_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_new;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff        <= '{ph: bdf_pkg::PH_LEAD, cand: '1, default: '0};
         bmode_ff      <= 1'b0;
         lpos_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            lex_ff   <= lex_in;
            bmode_ff <= bmode_in;
            lpos_ff  <= lpos_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_code_point   = $signed(out_ff.code_point);
   assign rsp_advance_x    = $signed(out_ff.advance_x);
   assign rsp_advance_y    = $signed(out_ff.advance_y);
   assign rsp_box_width    = $signed(out_ff.box_width);
   assign rsp_box_height   = $signed(out_ff.box_height);
   assign rsp_box_x_offset = $signed(out_ff.box_x_offset);
   assign rsp_box_y_offset = $signed(out_ff.box_y_offset);
   assign rsp_pixel_column = out_ff.pixel_column;
   assign rsp_pixel_row    = out_ff.pixel_row;
   assign rsp_nibble       = out_ff.nibble;

   // The skid entry is only ever filled behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a transaction while the result register is empty");

   // Bitmap mode is entered only on a line that also produced a glyph header.
   a_bitmap_entry: assert property (@(posedge clock) disable iff (reset)
      accept && !bmode_ff && bmode_in |-> res_valid && res_new.kind == bdf_pkg::KIND_HEADER
         && line_end)
      else $error("bitmap mode entered without a glyph header");

   // A line never runs past its length limit.
   a_line_limit: assert property (@(posedge clock) disable iff (reset)
      lpos_ff < LPOS_LAST)
      else $error("line position passed the line limit");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bdf_glyph_stream_parser: feeds BDF text one byte at a time
// and checks every glyph header, bitmap nibble and end-of-char error against a predictor.
// Depends on bdf_pkg for the response type, kind codes, phase codes and character codes.

module tb;

   localparam int LINE_LIMIT  = 256;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_BYTES = 75;
   localparam int N_ROWS      = 26;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_ch = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic signed [31:0] rsp_code_point, rsp_advance_x, rsp_advance_y;
   logic signed [31:0] rsp_box_width, rsp_box_height, rsp_box_x_offset, rsp_box_y_offset;
   logic [9:0] rsp_pixel_column;
   logic [15:0] rsp_pixel_row;
   logic [3:0] rsp_nibble;

   bdf_glyph_stream_parser #(.MAX_LINE(LINE_LIMIT)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_ch(req_ch),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_code_point(rsp_code_point), .rsp_advance_x(rsp_advance_x),
      .rsp_advance_y(rsp_advance_y), .rsp_box_width(rsp_box_width),
      .rsp_box_height(rsp_box_height), .rsp_box_x_offset(rsp_box_x_offset),
      .rsp_box_y_offset(rsp_box_y_offset), .rsp_pixel_column(rsp_pixel_column),
      .rsp_pixel_row(rsp_pixel_row), .rsp_nibble(rsp_nibble)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bdf_pkg::rsp_type glyph_due[$];
   logic [7:0] text_q[$];
   int mismatch_count = 0;
   int sent_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   // Predictor state for the line lexer and the latched glyph metrics.
   string kw_word[5] = '{"ENCODING", "DWIDTH", "BBX", "BITMAP", "ENDCHAR"};
   bit                  in_bitmap;
   int                  byte_in_line;
   bdf_pkg::phase_type  lex_phase;
   logic [4:0]          kw_alive;
   logic [8:0]          tok_len;
   bit                  in_quotes;
   logic [2:0]          arg_slot;
   logic [31:0]         num_acc;
   bit                  num_neg;
   logic [31:0]         enc_value;
   logic [31:0]         dw_value [0:1];
   logic [31:0]         bbx_value [0:3];
   logic [9:0]          pix_col;
   logic [15:0]         pix_row;

   function automatic bit digit_byte(input logic [7:0] c);
      return c >= bdf_pkg::CH_ZERO && c <= bdf_pkg::CH_NINE;
   endfunction

   function automatic logic [3:0] hex_of(input logic [7:0] c);
      if (digit_byte(c)) return 4'(c - bdf_pkg::CH_ZERO);
      if (c >= "a" && c <= "f") return 4'(c - 8'h61 + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - 8'h41 + 8'd10);
      return 4'd0;
   endfunction

   function automatic bit keyword_done(input int k);
      return kw_alive[k] && int'(tok_len) == kw_word[k].len();
   endfunction

   function automatic int arg_total();
      if (keyword_done(bdf_pkg::KW_ENCODING)) return 1;
      if (keyword_done(bdf_pkg::KW_DWIDTH)) return 2;
      if (keyword_done(bdf_pkg::KW_BBX)) return 4;
      return 0;
   endfunction

   task automatic take_token_char(input logic [7:0] c);
      for (int k = 0; k < 5; k++) begin
         if (int'(tok_len) >= kw_word[k].len() || 8'(kw_word[k][tok_len]) != c) begin
            kw_alive[k] = 1'b0;
         end
      end
      if (tok_len != bdf_pkg::TLEN_MAX) begin
         tok_len = tok_len + 9'd1;
      end
   endtask

   task automatic latch_arg(input logic [2:0] idx, input logic [31:0] v);
      if (keyword_done(bdf_pkg::KW_ENCODING)) begin
         if (idx == 3'd0) enc_value = v;
      end else if (keyword_done(bdf_pkg::KW_DWIDTH)) begin
         if (idx < 3'd2) dw_value[idx[0]] = v;
      end else if (keyword_done(bdf_pkg::KW_BBX)) begin
         if (idx < 3'd4) bbx_value[idx[1:0]] = v;
      end
   endtask

   task automatic close_token();
      int n;
      n = arg_total();
      if (in_bitmap || n == 0) begin
         lex_phase = bdf_pkg::PH_DONE;
      end else begin
         // Arguments that never appear on the line read as zero.
         for (int i = 0; i < n; i++) latch_arg(3'(i), 32'd0);
         arg_slot = 3'd0;
         num_acc = 32'd0;
         num_neg = 1'b0;
         lex_phase = bdf_pkg::PH_ARG;
      end
   endtask

   task automatic commit_number();
      latch_arg(arg_slot, num_neg ? 32'd0 - num_acc : num_acc);
      arg_slot = arg_slot + 3'd1;
      num_acc = 32'd0;
      num_neg = 1'b0;
      lex_phase = (int'(arg_slot) >= arg_total()) ? bdf_pkg::PH_DONE : bdf_pkg::PH_ARG;
   endtask

   task automatic open_number(input logic [7:0] c);
      if (c > bdf_pkg::CH_SPACE) begin
         if (c == bdf_pkg::CH_MINUS) begin
            num_neg = 1'b1;
            num_acc = 32'd0;
            lex_phase = bdf_pkg::PH_SIGN;
         end else if (digit_byte(c)) begin
            num_acc = 32'(c - bdf_pkg::CH_ZERO);
            lex_phase = bdf_pkg::PH_DIGITS;
         end else begin
            lex_phase = bdf_pkg::PH_DONE;
         end
      end
   endtask

   task automatic wrap_up_line();
      if (lex_phase == bdf_pkg::PH_TOKEN || lex_phase == bdf_pkg::PH_RUN) begin
         close_token();
      end else if (lex_phase == bdf_pkg::PH_SIGN || lex_phase == bdf_pkg::PH_DIGITS) begin
         commit_number();
      end
      lex_phase = bdf_pkg::PH_DONE;
   endtask

   task automatic restart_line();
      byte_in_line = 0;
      lex_phase = bdf_pkg::PH_LEAD;
      kw_alive = 5'h1F;
      tok_len = 9'd0;
      in_quotes = 1'b0;
      arg_slot = 3'd0;
      num_acc = 32'd0;
      num_neg = 1'b0;
      pix_col = 10'd0;
   endtask

   task automatic clear_glyph_state();
      in_bitmap = 1'b0;
      enc_value = 32'd0;
      dw_value = '{32'd0, 32'd0};
      bbx_value = '{32'd0, 32'd0, 32'd0, 32'd0};
      pix_row = 16'd0;
      restart_line();
   endtask

   task automatic pixel_nibble(input logic [7:0] c, output bdf_pkg::rsp_type r);
      r = '0;
      r.kind = bdf_pkg::KIND_NIBBLE;
      r.pixel_column = pix_col;
      r.pixel_row = pix_row;
      r.nibble = hex_of(c);
      pix_col = pix_col + 10'd4;
   endtask

   // Advances the predictor by one byte; got is set when the byte yields a result.
   task automatic parse_char(input logic [7:0] c, output bit got,
                             output bdf_pkg::rsp_type r);
      got = 1'b0;
      r = '0;
      if (lex_phase != bdf_pkg::PH_DONE) begin
         if (c == bdf_pkg::CH_NUL) begin
            wrap_up_line();
         end else begin
            case (lex_phase)
               bdf_pkg::PH_LEAD: begin
                  if (c > bdf_pkg::CH_SPACE) begin
                     if (c == bdf_pkg::CH_QUOTE) begin
                        in_quotes = 1'b1;
                        lex_phase = bdf_pkg::PH_TOKEN;
                     end else begin
                        take_token_char(c);
                        if (in_bitmap && c >= bdf_pkg::CH_ZERO) begin
                           pixel_nibble(c, r);
                           got = 1'b1;
                           lex_phase = bdf_pkg::PH_RUN;
                        end else begin
                           lex_phase = bdf_pkg::PH_TOKEN;
                        end
                     end
                  end
               end
               bdf_pkg::PH_TOKEN: begin
                  if (in_quotes) begin
                     if (c == bdf_pkg::CH_QUOTE) close_token();
                     else take_token_char(c);
                  end else if (c <= bdf_pkg::CH_SPACE) begin
                     close_token();
                  end else begin
                     take_token_char(c);
                  end
               end
               bdf_pkg::PH_RUN: begin
                  if (c <= bdf_pkg::CH_SPACE) begin
                     close_token();
                  end else begin
                     take_token_char(c);
                     if (c >= bdf_pkg::CH_ZERO) begin
                        pixel_nibble(c, r);
                        got = 1'b1;
                     end else begin
                        lex_phase = bdf_pkg::PH_TOKEN;
                     end
                  end
               end
               bdf_pkg::PH_ARG: open_number(c);
               bdf_pkg::PH_SIGN, bdf_pkg::PH_DIGITS: begin
                  if (digit_byte(c)) begin
                     if (lex_phase == bdf_pkg::PH_SIGN) num_acc = 32'(c - bdf_pkg::CH_ZERO);
                     else num_acc = num_acc * 32'd10 + 32'(c - bdf_pkg::CH_ZERO);
                     lex_phase = bdf_pkg::PH_DIGITS;
                  end else if (!(lex_phase == bdf_pkg::PH_SIGN && c <= bdf_pkg::CH_SPACE)) begin
                     // A minus right after a number opens the next argument.
                     commit_number();
                     if (lex_phase == bdf_pkg::PH_ARG) open_number(c);
                  end
               end
               default: lex_phase = bdf_pkg::PH_DONE;
            endcase
         end
      end
      byte_in_line++;
      if (c == bdf_pkg::CH_NEWLINE || byte_in_line >= LINE_LIMIT - 1) begin
         wrap_up_line();
         if (in_bitmap) begin
            if (keyword_done(bdf_pkg::KW_ENDCHAR)) in_bitmap = 1'b0;
            else if (tok_len != 9'd0 && pix_row != bdf_pkg::ROW_MAX) pix_row = pix_row + 16'd1;
         end else begin
            pix_row = 16'd0;
            if (keyword_done(bdf_pkg::KW_BITMAP)) begin
               r = '0;
               r.kind = bdf_pkg::KIND_HEADER;
               r.code_point = enc_value;
               r.advance_x = dw_value[0];
               r.advance_y = dw_value[1];
               r.box_width = bbx_value[0];
               r.box_height = bbx_value[1];
               r.box_x_offset = bbx_value[2];
               r.box_y_offset = bbx_value[3];
               in_bitmap = 1'b1;
               got = 1'b1;
            end else if (keyword_done(bdf_pkg::KW_ENDCHAR)) begin
               r = '0;
               r.kind = bdf_pkg::KIND_ERROR;
               got = 1'b1;
            end
         end
         restart_line();
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : rsp_check
      bdf_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (glyph_due.size() == 0) begin
               flag_mismatch("result arrived with nothing expected");
            end else begin
               want = glyph_due.pop_front();
               compare_field("kind", 32'(rsp_kind), 32'(want.kind));
               compare_field("code_point", rsp_code_point, want.code_point);
               compare_field("advance_x", rsp_advance_x, want.advance_x);
               compare_field("advance_y", rsp_advance_y, want.advance_y);
               compare_field("box_width", rsp_box_width, want.box_width);
               compare_field("box_height", rsp_box_height, want.box_height);
               compare_field("box_x_offset", rsp_box_x_offset, want.box_x_offset);
               compare_field("box_y_offset", rsp_box_y_offset, want.box_y_offset);
               compare_field("pixel_column", 32'(rsp_pixel_column), 32'(want.pixel_column));
               compare_field("pixel_row", 32'(rsp_pixel_row), 32'(want.pixel_row));
               compare_field("nibble", 32'(rsp_nibble), 32'(want.nibble));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bdf_glyph_stream_parser: mismatch");
         $finish;
      end
   end

   // Offers one byte, holds it until the parser takes it, then predicts its result.
   task automatic put_byte(input logic [7:0] c, input bit typed,
                           input bdf_pkg::rsp_type typed_rsp);
      bit got;
      bdf_pkg::rsp_type r;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(c, got, r);
      if (got) glyph_due.push_back(typed ? typed_rsp : r);
      sent_count++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) put_byte(text_q[i], 1'b0, '0);
      text_q.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (glyph_due.size() != 0);
   endtask

   function automatic string number_text();
      string extremes[5] = '{"-2147483648", "2147483647", "4294967295", "-0", "-"};
      case ($urandom_range(0, 7))
         0: return $sformatf("%0d", $signed($urandom()));
         1, 2: return $sformatf("%0d", $urandom_range(0, 40));
         3: return $sformatf("-%0d", $urandom_range(0, 40));
         4: return $sformatf("- %0d", $urandom_range(0, 99));
         5: return $sformatf("%0d%0d", $urandom(), $urandom());
         6: return extremes[$urandom_range(0, 4)];
         default: return $sformatf("%0dx", $urandom_range(0, 9));
      endcase
   endfunction

   task automatic keyword_line(input string kw, input int n_args);
      string s;
      string seps[3] = '{" ", "\t", "  "};
      s = ($urandom_range(0, 7) == 0) ? " " : "";
      s = {s, ($urandom_range(0, 9) == 0) ? {"\"", kw, "\""} : kw};
      for (int i = 0; i < n_args; i++) s = {s, seps[$urandom_range(0, 2)], number_text()};
      add_text({s, "\n"});
   endtask

   // One glyph record with random metrics and bitmap; some records are left broken.
   task automatic glyph_record();
      string hex_set;
      string s;
      int pick;
      hex_set = "0123456789ABCDEFabcdef";
      if ($urandom_range(0, 9) != 0) keyword_line("ENCODING", 1);
      if ($urandom_range(0, 9) != 0)
         keyword_line("DWIDTH", ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 2);
      if ($urandom_range(0, 9) != 0)
         keyword_line("BBX", ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : 4);
      keyword_line("BITMAP", 0);
      repeat ($urandom_range(0, 4)) begin
         s = ($urandom_range(0, 7) == 0) ? " " : "";
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 21);
            s = {s, hex_set.substr(pick, pick)};
         end
         if ($urandom_range(0, 9) == 0) s = {s, ($urandom_range(0, 1) == 0) ? "g" : " zz"};
         add_text({s, "\n"});
      end
      if ($urandom_range(0, 9) != 0) keyword_line("ENDCHAR", 0);
      send_text();
   endtask

   task automatic noise_line();
      string alphabet;
      alphabet = "ENCODINGDWIDTHBBXBITMAPENDCHAR -0123456789\"\t";
      repeat ($urandom_range(0, 24)) begin
         if ($urandom_range(0, 1) == 0) text_q.push_back(8'($urandom_range(0, 255)));
         else text_q.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
      end
      text_q.push_back(bdf_pkg::CH_NEWLINE);
      send_text();
   endtask

   // Directed lines. A \001 stands for a zero byte, which a string cannot hold.
   // A nonzero pad repeats the row's last character that many more times.
   string row_text [N_ROWS] = '{
      "ENDCHAR\n", "BITMAP\n", "0123456789abcdefABCDEFgG~\177\377\n", " \t3C /x 9\n",
      "\n", "BITMAP\n", "ENDCHAR\n", "ENCODING -2147483648\n", "DWIDTH 2147483647 -0\n",
      "BBX 4294967295 99999999999 - 7 -3-4\n", "\"BITMAP\"\n", "\"ENDCHAR\"\n",
      "ENCODING 12x 5\n", "DWIDTH 7 x\n", "\tBBX\t1\t2\n", "ENCODING\001 55\n",
      "BITMAPX\n", "ENDCHAR junk\n", "BITMAP ", "F", "DWIDTH -\n", "ENDCHAR\n",
      "DWIDTH -\n", "\"\"\n", "BITMAP\n", "ENDCHAR\n"
   };
   int row_pad [N_ROWS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                            248, 0, 0, 0, 0, 0, 0, 0};
   // Rows whose single result is plain to see: errors, and the header right after reset.
   bit row_typed [N_ROWS] = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                              0, 0, 0, 0, 0, 0, 0, 0};
   bdf_pkg::kind_type row_kind [N_ROWS] = '{bdf_pkg::KIND_ERROR, bdf_pkg::KIND_HEADER,
      bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE,
      bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE,
      bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE,
      bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_ERROR,
      bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE,
      bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE, bdf_pkg::KIND_NIBBLE};
   int idle_set [4] = '{0, 58, 0, 24};
   int stall_set [4] = '{0, 0, 58, 24};

   initial begin : stimulus
      logic [7:0] c;
      bdf_pkg::rsp_type typed;
      int phase_start;
      clear_glyph_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         typed = '0;
         typed.kind = row_kind[r];
         for (int j = 0; j < row_text[r].len(); j++) begin
            c = row_text[r][j];
            if (c == 8'h01) c = bdf_pkg::CH_NUL;
            put_byte(c, row_typed[r], typed);
         end
         repeat (row_pad[r]) put_byte(c, row_typed[r], typed);
      end

      // Hold the sender off until the parser has nothing left.
      drain_results();

      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 3) != 0) glyph_record();
            else noise_line();
         end
         drain_results();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && glyph_due.size() == 0) begin
         $display("bdf_glyph_stream_parser: match");
      end else begin
         $display("bdf_glyph_stream_parser: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/bdf_pkg.sv
src/bdf_glyph_stream_parser.sv
sim/tb.sv
